>>> design/matrix_quarter_turn_rotator_macros.svh
// ----------------------------------------------------------------------------
// matrix quarter turn rotator assertion macros
// shared concurrent assertion forms, reset gated
// ----------------------------------------------------------------------------
`ifndef MATRIX_QUARTER_TURN_ROTATOR_MACROS_SVH
`define MATRIX_QUARTER_TURN_ROTATOR_MACROS_SVH

// same-cycle implication
`define MQR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mqr assertion failed");

// next-cycle implication
`define MQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqr assertion failed");

`endif

>>> design/mqr_pkg.sv
// ----------------------------------------------------------------------------
// mqr_pkg
// types and constants shared by the quarter turn rotator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mqr_pkg;

  localparam int unsigned IDX_W   = 3;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned ORIENT_W = 2;

  typedef enum logic [1:0] {
    K_WRITE  = 2'd0,
    K_ROTATE = 2'd1,
    K_READ   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

>>> design/mqr_ctrl.sv
// ----------------------------------------------------------------------------
// mqr_ctrl
// request sequencer: capture, memory access, result hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqr_ctrl
  import mqr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/mqr_datapath.sv
// ----------------------------------------------------------------------------
// mqr_datapath
// view remap, element memory and orientation register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqr_datapath
  import mqr_pkg::*;
#(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  input  logic [1:0]                 kind,
  input  logic [IDX_W-1:0]           view_row,
  input  logic [IDX_W-1:0]           view_col,
  input  logic signed [VAL_W-1:0]    write_value,
  input  logic signed [VAL_W-1:0]    quarter_turns,
  output logic signed [VAL_W-1:0]    read_value,
  output logic [DIM_W-1:0]           view_rows,
  output logic [DIM_W-1:0]           view_cols,
  output logic [ORIENT_W-1:0]        orientation,
  output logic                       out_of_range
);

  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RXW   = $clog2(ROWS + 1);
  localparam int unsigned CXW   = $clog2(COLS + 1);
  localparam int unsigned DXW   = (RXW > CXW) ? RXW : CXW;
  localparam int unsigned XW    = (DXW > IDX_W) ? DXW : IDX_W;
  localparam int unsigned LW    = 2 * XW;

  logic [1:0]            kind_r;
  logic [IDX_W-1:0]      row_r;
  logic [IDX_W-1:0]      col_r;
  logic [VAL_W-1:0]      wval_r;
  logic [ORIENT_W-1:0]   turns_r;
  logic [ORIENT_W-1:0]   orient_r;
  logic                  oor_r;
  logic                  hit_r;
  logic [VAL_W-1:0]      mem_q_r;
  logic [VAL_W-1:0]      mem [DEPTH];

  logic [XW-1:0] vr;
  logic [XW-1:0] vc;
  logic [XW-1:0] rx;
  logic [XW-1:0] cx;
  logic [XW-1:0] sr;
  logic [XW-1:0] sc;
  logic [LW-1:0] lin;
  logic [AW-1:0] addr;
  logic          in_view;
  logic          is_access;
  logic          wr_en;
  logic          rd_en;

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind;
      row_r   <= view_row;
      col_r   <= view_col;
      wval_r  <= write_value;
      turns_r <= quarter_turns[ORIENT_W-1:0];
    end
  end

  // view bounds and remap onto stored row major position
  always_comb begin
    vr = orient_r[0] ? XW'(COLS) : XW'(ROWS);
    vc = orient_r[0] ? XW'(ROWS) : XW'(COLS);
    rx = XW'(row_r);
    cx = XW'(col_r);
    in_view = (rx < vr) && (cx < vc);
    case (orient_r)
      2'd0: begin
        sr = rx;
        sc = cx;
      end
      2'd1: begin
        sr = XW'(ROWS - 1) - cx;
        sc = rx;
      end
      2'd2: begin
        sr = XW'(ROWS - 1) - rx;
        sc = XW'(COLS - 1) - cx;
      end
      default: begin
        sr = cx;
        sc = XW'(COLS - 1) - rx;
      end
    endcase
    lin  = LW'(sr) * LW'(COLS) + LW'(sc);
    addr = lin[AW-1:0];
  end

  assign is_access = (kind_r == K_WRITE) || (kind_r == K_READ);
  assign wr_en     = cmd.exec && (kind_r == K_WRITE) && in_view;
  assign rd_en     = cmd.exec && (kind_r == K_READ) && in_view;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wval_r;
    end
    if (rd_en) begin
      mem_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= '0;
      oor_r    <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cmd.exec) begin
      oor_r <= is_access && !in_view;
      hit_r <= rd_en;
      if (kind_r == K_ROTATE) begin
        orient_r <= orient_r + turns_r;
      end
    end
  end

  assign read_value   = hit_r ? mem_q_r : '0;
  assign view_rows    = orient_r[0] ? DIM_W'(COLS) : DIM_W'(ROWS);
  assign view_cols    = orient_r[0] ? DIM_W'(ROWS) : DIM_W'(COLS);
  assign orientation  = orient_r;
  assign out_of_range = oor_r;

endmodule

>>> design/matrix_quarter_turn_rotator.sv
// ----------------------------------------------------------------------------
// matrix_quarter_turn_rotator
// ROWS x COLS element store viewed through an accumulated quarter turn
// ----------------------------------------------------------------------------
// usage: each request on the in_ channel writes an element, rotates the view
// or reads an element; kind travels on in_tuser. every request gives exactly
// one result on the out_ channel with the read value, the view size, the
// orientation and an out-of-range flag.
// sequencing: out_tvalid rises once the request has passed from the exec state
// into the done state; the sequencer captures the request, makes at most
// one memory access, then holds the result, and takes no new request
// until the result is taken. the element memory has one port, used at most
// once per request.
// reset: orientation returns to unrotated and any pending request is
// dropped; the element memory is not cleared, entries read before being
// written return undefined data.
// receiver stall: the result holds steady and in_tready stays low until
// out_tready is seen high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix_quarter_turn_rotator_macros.svh"

module matrix_quarter_turn_rotator
  import mqr_pkg::*;
#(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // view_row[2:0], view_col[5:3], write_value[37:6], quarter_turns[69:38]
  input  logic [71:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[31:0], view_rows[35:32], view_cols[39:36], orientation[41:40],
  // out_of_range[42]
  output logic [47:0] out_tdata
);

  cmd_t                    cmd;
  logic signed [VAL_W-1:0] read_value;
  logic [DIM_W-1:0]        view_rows;
  logic [DIM_W-1:0]        view_cols;
  logic [ORIENT_W-1:0]     orientation;
  logic                    out_of_range;

  mqr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mqr_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .kind          (in_tuser),
    .view_row      (in_tdata[2:0]),
    .view_col      (in_tdata[5:3]),
    .write_value   (in_tdata[37:6]),
    .quarter_turns (in_tdata[69:38]),
    .read_value    (read_value),
    .view_rows     (view_rows),
    .view_cols     (view_cols),
    .orientation   (orientation),
    .out_of_range  (out_of_range)
  );

  assign out_tdata = {5'd0, out_of_range, orientation, view_cols, view_rows, read_value};

  // one request in flight at a time
  `MQR_ASSERT_IMPL(a_single_request, clk, rst_n, out_tvalid, !in_tready)
  // out_tvalid follows acceptance once the exec state has passed
  `MQR_ASSERT_NEXT(a_latency, clk, rst_n, in_tvalid && in_tready, (##1 out_tvalid))
  // view size follows orientation parity
  `MQR_ASSERT_IMPL(a_view_dims, clk, rst_n, out_tvalid && !orientation[0], (view_rows == DIM_W'(ROWS)) && (view_cols == DIM_W'(COLS)))

endmodule
